/* hw/rtl/dds_hgs_pkg.sv */
// shared types, constants and codes for the surface header gate
package dds_hgs_pkg;

   localparam int SIDE_W      = 15;
   localparam int TEXELS_W    = 29;
   localparam int HDR_OFF_W   = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [SIDE_W-1:0] MAX_SIDE      = 15'd16384;
   localparam logic [SIDE_W-1:0] CAP_RESET     = 15'd4096;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HEIGHT = 1'b1;

   localparam logic [31:0] DDS_MAGIC    = 32'h2053_4444;
   localparam logic [31:0] FOURCC_DXT1  = 32'h3154_5844;
   localparam logic [31:0] FOURCC_DXT5  = 32'h3554_5844;
   localparam logic [31:0] HEADER_SIZE  = 32'd124;
   localparam logic [31:0] RGB_BITCOUNT = 32'd32;
   localparam logic [31:0] BLUE_LO_MASK = 32'h0000_00ff;
   localparam logic [31:0] RED_HI_MASK  = 32'h00ff_0000;
   localparam int          FLAG_FOURCC_BIT = 2;
   localparam int          FLAG_RGB_BIT    = 6;

   // header offsets of the last byte of each captured word
   localparam logic [HDR_OFF_W-1:0] OFF_MAGIC    = 7'd3;
   localparam logic [HDR_OFF_W-1:0] OFF_SIZE     = 7'd7;
   localparam logic [HDR_OFF_W-1:0] OFF_HEIGHT   = 7'd15;
   localparam logic [HDR_OFF_W-1:0] OFF_WIDTH    = 7'd19;
   localparam logic [HDR_OFF_W-1:0] OFF_FLAGS    = 7'd83;
   localparam logic [HDR_OFF_W-1:0] OFF_FOURCC   = 7'd87;
   localparam logic [HDR_OFF_W-1:0] OFF_BITCOUNT = 7'd91;
   localparam logic [HDR_OFF_W-1:0] OFF_RMASK    = 7'd95;
   localparam logic [HDR_OFF_W-1:0] OFF_BMASK    = 7'd103;
   localparam logic [HDR_OFF_W-1:0] OFF_LAST     = 7'd127;

   localparam logic [1:0] TEXEL_LAST_BYTE = 2'd3;

   localparam logic KIND_TEXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DRAIN   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SHORT       = 3'd1,
      ST_NOT_SURFACE = 3'd2,
      ST_BAD_SIZE    = 3'd3,
      ST_UNSUPPORTED = 3'd4,
      ST_TRUNCATED   = 3'd5,
      ST_DXT1        = 3'd6,
      ST_DXT5        = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic              kind;
      status_type        status;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      logic [SIDE_W-1:0] surface_width;
      logic [SIDE_W-1:0] surface_height;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } texel_type;

   // what the header said, boiled down to what classification needs
   typedef struct packed {
      logic              magic_ok;
      logic              size_ok;
      logic [SIDE_W-1:0] height;
      logic              height_big;
      logic [SIDE_W-1:0] width;
      logic              width_big;
      logic              fourcc_flag;
      logic              rgb_flag;
      logic              is_dxt1;
      logic              is_dxt5;
      logic              bits32;
      logic              red_hi;
      logic              blue_lo;
   } hdr_info_type;

   // one queue entry: an optional texel, then an optional status
   typedef struct packed {
      logic              has_texel;
      logic              has_status;
      texel_type         texel;
      status_type        status;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
   } cmd_type;

endpackage

/* hw/rtl/dds_hgs_front.sv */
// front end: byte intake, header capture, classification and texel assembly
module dds_hgs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  dds_hgs_pkg::req_type             req_payload,
   input  logic                             queue_full,
   input  logic [dds_hgs_pkg::SIDE_W-1:0]   cap_width,
   input  logic [dds_hgs_pkg::SIDE_W-1:0]   cap_height,
   output logic                             push,
   output dds_hgs_pkg::cmd_type             cmd
);
   import dds_hgs_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [HDR_OFF_W-1:0]  hdr_off_ff, hdr_off_in;
   logic [1:0]            pay_idx_ff, pay_idx_in;
   logic [23:0]           word_ff, word_in;
   hdr_info_type          info_ff, info_in;
   logic [7:0]            tb_ff [3];
   logic [7:0]            tb_in [3];
   logic                  blue_first_ff, blue_first_in;
   logic [TEXELS_W-1:0]   texels_left_ff, texels_left_in;
   logic [TEXELS_W-1:0]   area_ff;
   logic [2*SIDE_W-1:0]   area_full;

   logic                  accept;
   logic [7:0]            b;
   logic [31:0]           word_full;
   logic [SIDE_W-1:0]     cap_w, cap_h;
   logic                  dim_bad;
   status_type            cls;
   status_type            st;
   logic                  has_texel, has_status;
   texel_type             texel;

   assign accept    = req_valid && !queue_full;
   assign b         = req_payload.byte_value;
   assign word_full = {b, word_ff};
   assign cap_w     = (cap_width > MAX_SIDE) ? MAX_SIDE : cap_width;
   assign cap_h     = (cap_height > MAX_SIDE) ? MAX_SIDE : cap_height;
   assign area_full = info_ff.width * info_ff.height;

   assign dim_bad = info_ff.width_big || info_ff.height_big ||
                    (info_ff.width == '0) || (info_ff.height == '0) ||
                    (info_ff.width > cap_w) || (info_ff.height > cap_h);

   always_comb begin
      if (!(info_ff.magic_ok && info_ff.size_ok)) begin
         cls = ST_NOT_SURFACE;
      end else if (dim_bad) begin
         cls = ST_BAD_SIZE;
      end else if (info_ff.fourcc_flag && info_ff.is_dxt1) begin
         cls = ST_DXT1;
      end else if (info_ff.fourcc_flag && info_ff.is_dxt5) begin
         cls = ST_DXT5;
      end else if (info_ff.rgb_flag && info_ff.bits32) begin
         cls = ST_OK;
      end else begin
         cls = ST_UNSUPPORTED;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      hdr_off_in     = hdr_off_ff;
      pay_idx_in     = pay_idx_ff;
      word_in        = word_ff;
      info_in        = info_ff;
      tb_in          = tb_ff;
      blue_first_in  = blue_first_ff;
      texels_left_in = texels_left_ff;
      has_texel      = 1'b0;
      has_status     = 1'b0;
      st             = ST_OK;
      texel.red      = blue_first_ff ? tb_ff[2] : tb_ff[0];
      texel.green    = tb_ff[1];
      texel.blue     = blue_first_ff ? tb_ff[0] : tb_ff[2];
      texel.alpha    = b;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               hdr_off_in = hdr_off_ff + 7'd1;
               // little-endian word builds up from the top byte down
               word_in = {b, word_ff[23:8]};
               case (hdr_off_ff)
                  OFF_MAGIC: info_in.magic_ok = (word_full == DDS_MAGIC);
                  OFF_SIZE: info_in.size_ok = (word_full == HEADER_SIZE);
                  OFF_HEIGHT: begin
                     info_in.height     = word_full[SIDE_W-1:0];
                     info_in.height_big = |word_full[31:SIDE_W];
                  end
                  OFF_WIDTH: begin
                     info_in.width     = word_full[SIDE_W-1:0];
                     info_in.width_big = |word_full[31:SIDE_W];
                  end
                  OFF_FLAGS: begin
                     info_in.fourcc_flag = word_full[FLAG_FOURCC_BIT];
                     info_in.rgb_flag    = word_full[FLAG_RGB_BIT];
                  end
                  OFF_FOURCC: begin
                     info_in.is_dxt1 = (word_full == FOURCC_DXT1);
                     info_in.is_dxt5 = (word_full == FOURCC_DXT5);
                  end
                  OFF_BITCOUNT: info_in.bits32 = (word_full == RGB_BITCOUNT);
                  OFF_RMASK: info_in.red_hi = |(word_full & RED_HI_MASK);
                  OFF_BMASK: info_in.blue_lo = |(word_full & BLUE_LO_MASK);
                  OFF_LAST: begin
                     if (cls == ST_OK) begin
                        blue_first_in  = info_ff.blue_lo && info_ff.red_hi;
                        texels_left_in = area_ff;
                        pay_idx_in     = '0;
                        phase_in       = PH_PAYLOAD;
                     end else begin
                        phase_in = PH_DRAIN;
                     end
                  end
                  default: ;
               endcase
            end
            PH_PAYLOAD: begin
               pay_idx_in = pay_idx_ff + 2'd1;
               if (pay_idx_ff != TEXEL_LAST_BYTE) begin
                  tb_in[pay_idx_ff] = b;
               end else begin
                  has_texel = 1'b1;
                  if (texels_left_ff != '0) begin
                     texels_left_in = texels_left_ff - 1'b1;
                  end
                  if (texels_left_in == '0) begin
                     phase_in = PH_DRAIN;
                  end
               end
            end
            PH_DRAIN: ;
            default: ;
         endcase

         if (req_payload.end_of_file) begin
            has_status = 1'b1;
            if (phase_in == PH_HEADER) begin
               st = ST_SHORT;
            end else if (cls == ST_OK && texels_left_in != '0) begin
               st = ST_TRUNCATED;
            end else begin
               st = cls;
            end
            // rearm for the next file
            phase_in       = PH_HEADER;
            hdr_off_in     = '0;
            pay_idx_in     = '0;
            blue_first_in  = 1'b0;
            texels_left_in = '0;
         end
      end
   end

   always_comb begin
      push           = has_texel || has_status;
      cmd.has_texel  = has_texel;
      cmd.has_status = has_status;
      cmd.texel      = texel;
      cmd.status     = st;
      if (st inside {ST_OK, ST_DXT1, ST_DXT5}) begin
         cmd.width  = info_ff.width;
         cmd.height = info_ff.height;
      end else begin
         cmd.width  = '0;
         cmd.height = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         hdr_off_ff     <= '0;
         pay_idx_ff     <= '0;
         blue_first_ff  <= 1'b0;
         texels_left_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         hdr_off_ff     <= hdr_off_in;
         pay_idx_ff     <= pay_idx_in;
         blue_first_ff  <= blue_first_in;
         texels_left_ff <= texels_left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      info_ff <= info_in;
      tb_ff   <= tb_in;
      // texel count, ready long before the header ends
      area_ff <= area_full[TEXELS_W-1:0];
   end

endmodule

/* hw/rtl/dds_hgs_queue.sv */
// short command queue between the front end and the result stage
module dds_hgs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dds_hgs_pkg::cmd_type  cmd_in,
   input  logic                  pop,
   output dds_hgs_pkg::cmd_type  head,
   output logic                  empty,
   output logic                  full
);
   import dds_hgs_pkg::*;

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head    = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

/* hw/rtl/dds_hgs_back.sv */
// result stage: expands queued commands into texel and status results
module dds_hgs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  dds_hgs_pkg::cmd_type  head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dds_hgs_pkg::rsp_type  rsp_payload
);
   import dds_hgs_pkg::*;

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;
   logic     half_ff, half_in;
   logic     advance;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      half_in      = half_ff;
      if (advance) begin
         rsp_valid_in = !q_empty;
         if (!q_empty) begin
            if (head.has_texel && !half_ff) begin
               rsp_in.kind           = KIND_TEXEL;
               rsp_in.status         = ST_OK;
               rsp_in.red            = head.texel.red;
               rsp_in.green          = head.texel.green;
               rsp_in.blue           = head.texel.blue;
               rsp_in.alpha          = head.texel.alpha;
               rsp_in.surface_width  = '0;
               rsp_in.surface_height = '0;
               rsp_in.last           = 1'b0;
               // texel plus status from one byte: keep the entry for a second beat
               if (head.has_status) begin
                  half_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               rsp_in.kind           = KIND_STATUS;
               rsp_in.status         = head.status;
               rsp_in.red            = '0;
               rsp_in.green          = '0;
               rsp_in.blue           = '0;
               rsp_in.alpha          = '0;
               rsp_in.surface_width  = head.width;
               rsp_in.surface_height = head.height;
               rsp_in.last           = 1'b1;
               pop                   = 1'b1;
               half_in               = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

/* hw/rtl/dds_header_gate_and_swizzle.sv */
// top level: surface header gate with RGBA texel output
// an accepted byte's command is written to the queue, then loaded into the result register
// throughput: one byte per cycle while the queue is not full; the front end does header
// capture and texel assembly per byte, and the result register emits one result per cycle
// unless stalled; a final byte completing a texel yields two results, texel then status
// reset: synchronous, active high; clears the file state and queue, caps return to 4096
module dds_header_gate_and_swizzle (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dds_hgs_pkg::req_type                 req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dds_hgs_pkg::rsp_type                 rsp_payload,
   input  logic                                 csr_write,
   input  logic [dds_hgs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dds_hgs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dds_hgs_pkg::*;

   logic [SIDE_W-1:0]  max_width_ff, max_width_in;
   logic [SIDE_W-1:0]  max_height_ff, max_height_in;
   logic               queue_full, queue_empty;
   logic               push, pop;
   cmd_type            cmd, head;

   always_comb begin
      max_width_in  = max_width_ff;
      max_height_in = max_height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_WIDTH:  max_width_in  = csr_wdata[SIDE_W-1:0];
            CSR_MAX_HEIGHT: max_height_in = csr_wdata[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff  <= CAP_RESET;
         max_height_ff <= CAP_RESET;
      end else begin
         max_width_ff  <= max_width_in;
         max_height_ff <= max_height_in;
      end
   end

   assign req_stall = queue_full;

   dds_hgs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .cap_width   (max_width_ff),
      .cap_height  (max_height_ff),
      .push        (push),
      .cmd         (cmd)
   );

   dds_hgs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (cmd),
      .pop    (pop),
      .head   (head),
      .empty  (queue_empty),
      .full   (queue_full)
   );

   dds_hgs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/dds_hgs_checker.sv */
// port-level checks for the surface header gate, bound to the top level
module dds_hgs_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  dds_hgs_pkg::rsp_type  rsp_payload
);
   import dds_hgs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_texel_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_TEXEL |->
         !rsp_payload.last && rsp_payload.status == ST_OK &&
         rsp_payload.surface_width == '0 && rsp_payload.surface_height == '0)
      else $error("texel result carries status fields");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_STATUS |->
         rsp_payload.last && rsp_payload.red == '0 && rsp_payload.green == '0 &&
         rsp_payload.blue == '0 && rsp_payload.alpha == '0)
      else $error("status result carries texel fields");

   // sizes only go out on an accepted or reported surface
   a_status_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_STATUS && rsp_payload.status != ST_OK &&
         rsp_payload.status != ST_DXT1 && rsp_payload.status != ST_DXT5 |->
         rsp_payload.surface_width == '0 && rsp_payload.surface_height == '0)
      else $error("size reported on a failed file");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind dds_header_gate_and_swizzle dds_hgs_checker u_checker (.*);
